FILE: hw/rtl/assert_macros.svh
// assertion macros for the rtl files that check themselves
// depends on nothing; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on a named clock and active-low reset
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// concurrent assertion on the usual clk_i and rst_ni
`define ASSERT_CLK(label, prop, msg) \
  `ASSERT_AT(label, clk_i, rst_ni, prop, msg)

`endif

FILE: hw/rtl/kth_pkg.sv
// shared types and constants for the k-th smallest rank query block
// no dependencies
package kth_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned RANK_W        = 12;
  localparam int unsigned DEFAULT_DEPTH = 1024;

  // operation codes of a request
  typedef enum logic [1:0] {
    OP_PUSH_A = 2'd0,
    OP_PUSH_B = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  // status codes of a result
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FOUND = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // request payload
  typedef struct packed {
    logic [1:0]               operation;
    logic signed [DATA_W-1:0] element_value;
    logic [RANK_W-1:0]        kth_rank;
  } req_t;

  // result payload
  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [1:0]               status;
  } rsp_t;

  // search engine completion
  typedef struct packed {
    logic                     done;
    logic                     found;
    logic signed [DATA_W-1:0] value;
  } srch_rsp_t;

endpackage

FILE: hw/rtl/kth_smallest_two_sorted_arrays_top.sv
// top level of the k-th smallest rank query over two ascending arrays
// depends on kth_pkg, kth_ram, kth_search and assert_macros.svh
//
// usage:
//   a request (req_i) is taken at a rising edge with start high and busy low.
//   every request gives exactly one result on rsp_o, shown for one cycle
//   with result_valid_o high; the receiver has no way to stall it.
//   push to a or b appends element_value at the array's fill count; a full
//   array drops the value with status full. clear empties both arrays.
//   push and clear results appear the cycle after the request, and busy
//   stays low, so one of them can be taken every cycle.
//   a query with rank 0 or above the combined count answers out of range
//   the cycle after the request. otherwise the search runs binary search
//   steps of a read state and an evaluate state, at most 11 steps at a
//   depth of 1024, plus a last read state when no partition is found; busy
//   stays high while it runs and the result strobe comes in the same cycle in which busy falls.
//   reset clears the fill counts and the sequencer; array contents are
//   left as they are and are never used above the counts.
module kth_smallest_two_sorted_arrays_top
  import kth_pkg::*;
#(
  parameter int unsigned ARRAY_DEPTH = DEFAULT_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic result_valid_o,
  output rsp_t rsp_o
);

  `include "assert_macros.svh"

  localparam int unsigned CW = $clog2(ARRAY_DEPTH + 1);
  localparam int unsigned AW = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;
  localparam int unsigned KW = CW + 1;
  localparam int unsigned SW = (CW + 1 > RANK_W) ? CW + 1 : RANK_W;

  logic [CW-1:0] count_a_q, count_a_d, count_b_q, count_b_d;
  logic          valid_q, valid_d;
  rsp_t          rsp_q, rsp_d;

  logic          accept, full_a, full_b, we_a, we_b, go, range_bad;
  logic [SW-1:0] total, k_ext;
  srch_rsp_t     srch_rsp;
  logic          srch_busy;

  logic [AW-1:0] a_addr_l, a_addr_r, b_addr_l, b_addr_r;
  logic signed [DATA_W-1:0] a_data_l, a_data_r, b_data_l, b_data_r;

  // request decode and range check
  always_comb begin
    accept    = start && !busy;
    full_a    = (count_a_q == CW'(ARRAY_DEPTH));
    full_b    = (count_b_q == CW'(ARRAY_DEPTH));
    total     = SW'(count_a_q) + SW'(count_b_q);
    k_ext     = SW'(req_i.kth_rank);
    range_bad = (k_ext == '0) || (k_ext > total);
    we_a      = accept && (req_i.operation == OP_PUSH_A) && !full_a;
    we_b      = accept && (req_i.operation == OP_PUSH_B) && !full_b;
    go        = accept && (req_i.operation == OP_QUERY) && !range_bad;
  end

  // counts and result register next values
  always_comb begin
    count_a_d = count_a_q;
    count_b_d = count_b_q;
    valid_d   = 1'b0;
    rsp_d     = rsp_q;
    if (accept) begin
      rsp_d.result_value = '0;
      rsp_d.status       = ST_OK;
      case (req_i.operation)
        OP_PUSH_A: begin
          valid_d = 1'b1;
          if (full_a) begin
            rsp_d.status = ST_FULL;
          end else begin
            count_a_d = count_a_q + CW'(1);
          end
        end
        OP_PUSH_B: begin
          valid_d = 1'b1;
          if (full_b) begin
            rsp_d.status = ST_FULL;
          end else begin
            count_b_d = count_b_q + CW'(1);
          end
        end
        OP_QUERY: begin
          if (range_bad) begin
            valid_d      = 1'b1;
            rsp_d.status = ST_RANGE;
          end
        end
        OP_CLEAR: begin
          valid_d   = 1'b1;
          count_a_d = '0;
          count_b_d = '0;
        end
        default: begin
          valid_d = 1'b0;
        end
      endcase
    end else if (srch_rsp.done) begin
      valid_d            = 1'b1;
      rsp_d.result_value = srch_rsp.found ? srch_rsp.value : '0;
      rsp_d.status       = srch_rsp.found ? ST_FOUND : ST_RANGE;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_a_q <= '0;
      count_b_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      count_a_q <= count_a_d;
      count_b_q <= count_b_d;
      valid_q   <= valid_d;
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign busy           = srch_busy;
  assign result_valid_o = valid_q;
  assign rsp_o          = rsp_q;

  // array a storage
  kth_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ARRAY_DEPTH)
  ) u_ram_a (
    .clk_i    (clk_i),
    .we_i     (we_a),
    .waddr_i  (AW'(count_a_q)),
    .wdata_i  (req_i.element_value),
    .raddr0_i (a_addr_l),
    .raddr1_i (a_addr_r),
    .rdata0_o (a_data_l),
    .rdata1_o (a_data_r)
  );

  // array b storage
  kth_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ARRAY_DEPTH)
  ) u_ram_b (
    .clk_i    (clk_i),
    .we_i     (we_b),
    .waddr_i  (AW'(count_b_q)),
    .wdata_i  (req_i.element_value),
    .raddr0_i (b_addr_l),
    .raddr1_i (b_addr_r),
    .rdata0_o (b_data_l),
    .rdata1_o (b_data_r)
  );

  // partition search engine
  kth_search #(
    .ARRAY_DEPTH (ARRAY_DEPTH)
  ) u_search (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (go),
    .k_i        (KW'(req_i.kth_rank)),
    .count_a_i  (count_a_q),
    .count_b_i  (count_b_q),
    .a_addr_l_o (a_addr_l),
    .a_addr_r_o (a_addr_r),
    .b_addr_l_o (b_addr_l),
    .b_addr_r_o (b_addr_r),
    .a_data_l_i (a_data_l),
    .a_data_r_i (a_data_r),
    .b_data_l_i (b_data_l),
    .b_data_r_i (b_data_r),
    .busy_o     (srch_busy),
    .rsp_o      (srch_rsp)
  );

  // checks
  `ASSERT_CLK(a_strobe_not_busy, result_valid_o |-> !busy, "result strobe while search runs")
  `ASSERT_CLK(a_push_answers, (accept && (req_i.operation != OP_QUERY)) |=> result_valid_o, "push or clear without result")
  `ASSERT_CLK(a_count_a_bound, count_a_q <= CW'(ARRAY_DEPTH), "count of array a above depth")
  `ASSERT_CLK(a_count_b_bound, count_b_q <= CW'(ARRAY_DEPTH), "count of array b above depth")
  `ASSERT_CLK(a_done_in_search, srch_rsp.done |-> srch_busy, "search done while idle")

endmodule

FILE: hw/rtl/kth_ram.sv
// generic simple ram: one write port, two registered read ports
// no dependencies
module kth_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr0_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr1_i,
  output logic [WIDTH-1:0]                      rdata0_o,
  output logic [WIDTH-1:0]                      rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read ports
  always_ff @(posedge clk_i) begin
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

FILE: hw/rtl/kth_search.sv
// binary search over partition points of the shorter array
// depends on kth_pkg; drives the read ports of both array rams
module kth_search
  import kth_pkg::*;
#(
  parameter int unsigned ARRAY_DEPTH = DEFAULT_DEPTH,
  localparam int unsigned CW = $clog2(ARRAY_DEPTH + 1),
  localparam int unsigned AW = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1,
  localparam int unsigned KW = CW + 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     go_i,
  input  logic [KW-1:0]            k_i,
  input  logic [CW-1:0]            count_a_i,
  input  logic [CW-1:0]            count_b_i,
  output logic [AW-1:0]            a_addr_l_o,
  output logic [AW-1:0]            a_addr_r_o,
  output logic [AW-1:0]            b_addr_l_o,
  output logic [AW-1:0]            b_addr_r_o,
  input  logic signed [DATA_W-1:0] a_data_l_i,
  input  logic signed [DATA_W-1:0] a_data_r_i,
  input  logic signed [DATA_W-1:0] b_data_l_i,
  input  logic signed [DATA_W-1:0] b_data_r_i,
  output logic                     busy_o,
  output srch_rsp_t                rsp_o
);

  localparam int unsigned IW = CW + 2;
  localparam logic signed [IW-1:0] ONE = IW'(1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EVAL = 3'b100
  } state_e;

  state_e               state_q, state_d;
  logic                 swap_q;
  logic [KW-1:0]        k_q;
  logic [CW-1:0]        n1_q, n2_q;
  logic signed [IW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [CW-1:0]        m1_q, m1_d, m2_q, m2_d;

  logic                 swap_d;
  logic [CW-1:0]        n1_d, n2_d;
  logic signed [IW-1:0] lo_init, hi_init, diff;
  logic [IW-1:0]        sum_w, m2_w;
  logic [AW-1:0]        p_addr_l, p_addr_r, q_addr_l, q_addr_r;
  logic signed [DATA_W-1:0] p_l, p_r, q_l, q_r;
  logic                 l1_inf, r1_inf, l2_inf, r2_inf;
  logic                 le1, le2;

  // shorter array becomes p, bounds of the partition range
  always_comb begin
    swap_d  = count_a_i > count_b_i;
    n1_d    = swap_d ? count_b_i : count_a_i;
    n2_d    = swap_d ? count_a_i : count_b_i;
    diff    = $signed({1'b0, k_i}) - $signed({2'b00, n2_d});
    lo_init = diff[IW-1] ? '0 : diff;
    hi_init = (k_i < KW'(n1_d)) ? $signed({1'b0, k_i}) : $signed({2'b00, n1_d});
  end

  // midpoint and addresses of the four neighbours
  always_comb begin
    sum_w    = IW'(lo_q + hi_q);
    m1_d     = CW'(sum_w >> 1);
    m2_w     = {1'b0, k_q} - {2'b00, m1_d};
    m2_d     = CW'(m2_w);
    p_addr_l = AW'(m1_d - CW'(1));
    p_addr_r = AW'(m1_d);
    q_addr_l = AW'(m2_d - CW'(1));
    q_addr_r = AW'(m2_d);
    a_addr_l_o = swap_q ? q_addr_l : p_addr_l;
    a_addr_r_o = swap_q ? q_addr_r : p_addr_r;
    b_addr_l_o = swap_q ? p_addr_l : q_addr_l;
    b_addr_r_o = swap_q ? p_addr_r : q_addr_r;
  end

  // neighbour values with missing ends as infinities
  always_comb begin
    p_l    = swap_q ? b_data_l_i : a_data_l_i;
    p_r    = swap_q ? b_data_r_i : a_data_r_i;
    q_l    = swap_q ? a_data_l_i : b_data_l_i;
    q_r    = swap_q ? a_data_r_i : b_data_r_i;
    l1_inf = (m1_q == '0);
    r1_inf = (m1_q == n1_q);
    l2_inf = (m2_q == '0);
    r2_inf = (m2_q == n2_q);
    le1    = l1_inf | r2_inf | (p_l <= q_r);
    le2    = l2_inf | r1_inf | (q_l <= p_r);
  end

  // search sequencer
  always_comb begin
    state_d = state_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    rsp_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (go_i) begin
          lo_d    = lo_init;
          hi_d    = hi_init;
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (lo_q > hi_q) begin
          rsp_o.done = 1'b1;
          state_d    = S_IDLE;
        end else begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (le1 && le2) begin
          rsp_o.done  = 1'b1;
          rsp_o.found = 1'b1;
          if (l1_inf) begin
            rsp_o.value = q_l;
          end else if (l2_inf) begin
            rsp_o.value = p_l;
          end else begin
            rsp_o.value = (p_l > q_l) ? p_l : q_l;
          end
          state_d = S_IDLE;
        end else begin
          if (!le1) begin
            hi_d = $signed({2'b00, m1_q}) - ONE;
          end else begin
            lo_d = $signed({2'b00, m1_q}) + ONE;
          end
          state_d = S_READ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // search datapath registers
  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
    if (state_q == S_IDLE && go_i) begin
      swap_q <= swap_d;
      k_q    <= k_i;
      n1_q   <= n1_d;
      n2_q   <= n2_d;
    end
    if (state_q == S_READ) begin
      m1_q <= m1_d;
      m2_q <= m2_d;
    end
  end

endmodule

FILE: dv/kth_checker.sv
// checker for the k-th smallest rank query block: watches request and result channels
// keeps its own copy of both arrays, predicts each result and compares in order
// depends on kth_pkg
module kth_checker
  import kth_pkg::*;
#(
  parameter int unsigned DEPTH = DEFAULT_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic busy_i,
  input  req_t req_i,
  input  logic result_valid_i,
  input  rsp_t rsp_i,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // a neighbour of a partition point; inf is -1, 0 or +1
  typedef struct {
    int                       inf;
    logic signed [DATA_W-1:0] v;
  } bound_t;

  logic signed [DATA_W-1:0] mem_a [DEPTH];
  logic signed [DATA_W-1:0] mem_b [DEPTH];
  int   fill_a;
  int   fill_b;
  int   fails;
  int   pending;
  rsp_t expected_rsp_q [$];
  rsp_t want;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  // neighbour read; outside the filled range it stands for an infinity
  function automatic bound_t fetch_bound(bit from_b, int idx, int n, int inf_dir);
    bound_t b;
    b.inf = inf_dir;
    b.v   = '0;
    if (idx >= 0 && idx < n) begin
      b.inf = 0;
      b.v   = from_b ? mem_b[idx] : mem_a[idx];
    end
    return b;
  endfunction

  function automatic bit bound_le(bound_t x, bound_t y);
    if (x.inf < 0 || y.inf > 0) return 1'b1;
    if (x.inf > 0 || y.inf < 0) return 1'b0;
    return x.v <= y.v;
  endfunction

  // binary search over the partition points of the shorter array
  function automatic bit rank_search(int k, output logic signed [DATA_W-1:0] value);
    bit     short_b;
    int     n1, n2, lo, hi, m1, m2;
    bound_t l1, r1, l2, r2;
    short_b = fill_a > fill_b;
    n1      = short_b ? fill_b : fill_a;
    n2      = short_b ? fill_a : fill_b;
    lo      = (k - n2 > 0) ? k - n2 : 0;
    hi      = (k < n1) ? k : n1;
    value   = '0;
    while (lo <= hi) begin
      m1 = (lo + hi) / 2;
      m2 = k - m1;
      l1 = fetch_bound(short_b, m1 - 1, n1, -1);
      r1 = fetch_bound(short_b, m1, n1, 1);
      l2 = fetch_bound(!short_b, m2 - 1, n2, -1);
      r2 = fetch_bound(!short_b, m2, n2, 1);
      if (bound_le(l1, r2) && bound_le(l2, r1)) begin
        if (l1.inf != 0) value = l2.v;
        else if (l2.inf != 0) value = l1.v;
        else value = (l1.v > l2.v) ? l1.v : l2.v;
        return 1'b1;
      end
      if (!bound_le(l1, r2)) hi = m1 - 1;
      else lo = m1 + 1;
    end
    return 1'b0;
  endfunction

  // expected result of one request, updating the array copies
  function automatic rsp_t next_rsp(req_t r);
    rsp_t                     p;
    int                       k;
    logic signed [DATA_W-1:0] v;
    p.result_value = '0;
    p.status       = ST_OK;
    k              = int'(r.kth_rank);
    case (op_e'(r.operation))
      OP_PUSH_A: begin
        if (fill_a >= int'(DEPTH)) p.status = ST_FULL;
        else begin
          mem_a[fill_a] = r.element_value;
          fill_a++;
        end
      end
      OP_PUSH_B: begin
        if (fill_b >= int'(DEPTH)) p.status = ST_FULL;
        else begin
          mem_b[fill_b] = r.element_value;
          fill_b++;
        end
      end
      OP_QUERY: begin
        if (k == 0 || k > fill_a + fill_b) p.status = ST_RANGE;
        else if (rank_search(k, v)) begin
          p.status       = ST_FOUND;
          p.result_value = v;
        end else p.status = ST_RANGE;
      end
      default: begin
        fill_a = 0;
        fill_b = 0;
      end
    endcase
    return p;
  endfunction

  // compare the result of this cycle first, then record a new request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_a = 0;
      fill_b = 0;
      expected_rsp_q.delete();
      pending = 0;
    end else begin
      if (result_valid_i) begin
        if (expected_rsp_q.size() == 0) begin
          $error("result with no request outstanding: result_value %0d status %0d",
                 rsp_i.result_value, rsp_i.status);
          fails++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_i.result_value !== want.result_value) begin
            $error("result_value: expected %0d, actual %0d", want.result_value,
                   rsp_i.result_value);
            fails++;
          end
          if (rsp_i.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_i.status);
            fails++;
          end
        end
      end
      if (start_i && !busy_i) begin
        expected_rsp_q.insert(expected_rsp_q.size(), next_rsp(req_i));
      end
      pending = expected_rsp_q.size();
    end
  end

endmodule

FILE: dv/kth_smallest_two_sorted_arrays_top_test.sv
// top of the rank query testbench: clock, reset, request stimulus and verdict
// depends on kth_pkg, kth_checker and kth_smallest_two_sorted_arrays_top
module kth_smallest_two_sorted_arrays_top_test
  import kth_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = DEFAULT_DEPTH;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic result_valid_o;
  rsp_t rsp_o;
  int   fails;
  int   pending;

  bit   idle_en;
  int   counted;
  logic signed [DATA_W-1:0] asc_a_q [$];
  logic signed [DATA_W-1:0] asc_b_q [$];

  always #5 clk_i = ~clk_i;

  kth_smallest_two_sorted_arrays_top #(
    .ARRAY_DEPTH(DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_i         (req_i),
    .result_valid_o(result_valid_o),
    .rsp_o         (rsp_o)
  );

  kth_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .req_i         (req_i),
    .result_valid_i(result_valid_o),
    .rsp_i         (rsp_o),
    .fail_count_o  (fails),
    .pending_o     (pending)
  );

  function automatic logic [RANK_W-1:0] rand_rank();
    return RANK_W'($urandom_range(0, (1 << RANK_W) - 1));
  endfunction

  // one request; start stays high when requests follow back to back
  task automatic send(op_e op, logic signed [DATA_W-1:0] val, logic [RANK_W-1:0] k);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    req_i = '{operation: op, element_value: val, kth_rank: k};
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    counted++;
  endtask

  task automatic push(bit to_b, logic signed [DATA_W-1:0] v);
    send(to_b ? OP_PUSH_B : OP_PUSH_A, v, rand_rank());
  endtask

  task automatic query(int k);
    send(OP_QUERY, $urandom, k[RANK_W-1:0]);
  endtask

  task automatic clear_all();
    send(OP_CLEAR, $urandom, rand_rank());
  endtask

  // rank choice: mostly in range, sometimes on or past the edges
  function automatic int pick_rank(int total);
    int r;
    r = $urandom_range(0, 19);
    if (r < 16) return (total == 0) ? 0 : $urandom_range(1, total);
    if (r == 16) return 0;
    if (r == 17) return total + 1;
    if (r == 18) return total;
    return $urandom_range(0, (1 << RANK_W) - 1);
  endfunction

  // array sizes: mostly small, now and then somewhat larger
  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 90) return $urandom_range(0, 24);
    return $urandom_range(25, 64);
  endfunction

  // ascending value list in one of several spreads
  task automatic make_ascending(bit for_b, int n);
    longint cur, span;
    int     mode;
    logic signed [DATA_W-1:0] q [$];
    mode = $urandom_range(0, 3);
    case (mode)
      0:       cur = longint'($signed($urandom));
      1:       cur = -64'sd2147483648;
      2:       cur = longint'($urandom_range(0, 8)) - 4;
      default: cur = longint'($signed($urandom));
    endcase
    span = 64'd4294967295 / (n + 1);
    for (int i = 0; i < n; i++) begin
      q.insert(q.size(), cur[DATA_W-1:0]);
      case (mode)
        0:       cur += $urandom_range(0, 7);
        1:       cur += $urandom_range(0, int'(span));
        2:       cur += $urandom_range(0, 2);
        default: cur += longint'($urandom);
      endcase
      if (cur > 64'sd2147483647) cur = 64'sd2147483647;
    end
    if (for_b) asc_b_q = q;
    else asc_a_q = q;
  endtask

  // clear, fill both arrays interleaved, query along the way and at the end
  task automatic sorted_run(int na, int nb, bit broken);
    int ia, ib, idx;
    ia = 0;
    ib = 0;
    clear_all();
    make_ascending(1'b0, na);
    make_ascending(1'b1, nb);
    // one entry overwritten with a random value can break the ordering
    if (broken) begin
      if ($urandom_range(0, 1) && na > 1) begin
        idx = $urandom_range(0, na - 1);
        asc_a_q[idx] = $urandom;
      end else if (nb > 1) begin
        idx = $urandom_range(0, nb - 1);
        asc_b_q[idx] = $urandom;
      end
    end
    while (ia < na || ib < nb) begin
      if (ib >= nb || (ia < na && $urandom_range(0, 1))) begin
        push(1'b0, asc_a_q[ia]);
        ia++;
      end else begin
        push(1'b1, asc_b_q[ib]);
        ib++;
      end
      if ($urandom_range(0, 7) == 0) query(pick_rank(ia + ib));
    end
    repeat ($urandom_range(1, 8)) query(pick_rank(na + nb));
  endtask

  // unordered traffic of every kind
  task automatic noise_run(int n);
    int k;
    repeat (n) begin
      k = $urandom_range(0, 1) ? $urandom_range(0, (1 << RANK_W) - 1) : $urandom_range(0, 40);
      send(op_e'($urandom_range(0, 3)), $urandom, k[RANK_W-1:0]);
    end
  endtask

  // timeout
  initial begin
    #5_000_000;
    $display("kth_smallest_two_sorted_arrays_top test failed");
    $finish;
  end

  initial begin
    int r;
    rst_ni  = 1'b0;
    start   = 1'b0;
    req_i   = '0;
    idle_en = 1'b1;
    counted = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty arrays, value extremes, rank edges, clear, unsorted
    query(0);
    query(1);
    push(1'b0, VAL_MIN);
    push(1'b0, -5);
    push(1'b0, 0);
    push(1'b0, 7);
    push(1'b0, VAL_MAX);
    push(1'b1, VAL_MIN);
    push(1'b1, 3);
    push(1'b1, VAL_MAX);
    query(1);
    query(4);
    query(8);
    query(9);
    query(0);
    query((1 << RANK_W) - 1);
    clear_all();
    query(1);
    push(1'b0, 10);
    push(1'b0, 5);
    push(1'b1, 7);
    query(1);
    query(2);
    query(3);
    clear_all();

    // random sequences, idling switched on and off per sequence
    while (counted < 770) begin
      idle_en = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 70) sorted_run(pick_size(), pick_size(), 1'b0);
      else if (r < 85) sorted_run(pick_size(), pick_size(), 1'b1);
      else noise_run($urandom_range(1, 20));
    end

    // closing stretch without idling
    idle_en = 1'b0;
    sorted_run($urandom_range(1, 24), $urandom_range(1, 24), 1'b0);
    noise_run(10);
    start = 1'b0;

    for (int w = 0; w < 2000 && pending != 0; w++) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("kth_smallest_two_sorted_arrays_top test passed");
    end else begin
      $display("kth_smallest_two_sorted_arrays_top test failed");
    end
    $finish;
  end

endmodule
